// ===== design/ppqm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppqm_pkg
// Shared types, widths and constants for the pitch PID quad motor mixer.
// ----------------------------------------------------------------------------
package ppqm_pkg;

  // stream and register port widths
  localparam int InDataW  = 88;
  localparam int OutDataW = 56;
  localparam int AddrW    = 5;
  localparam int CfgDataW = 32;

  // field widths
  localparam int AngleW = 24;
  localparam int DtW    = 10;
  localparam int ChW    = 12;
  localparam int DutyW  = 10;
  localparam int SumW   = 12;
  localparam int GainW  = 16;
  localparam int IlimW  = 23;
  localparam int SlimW  = 11;

  // input word field offsets
  localparam int AngleLsb = 0;
  localparam int RateLsb  = 24;
  localparam int DtLsb    = 48;
  localparam int PchLsb   = 58;
  localparam int TchLsb   = 70;

  // shared multiplier and accumulator widths
  localparam int MulAW = 25;
  localparam int MulBW = 17;
  localparam int ProdW = 42;
  localparam int AccW  = 44;
  localparam int TruncW = AccW - 20;

  // shared divider: 40-bit magnitude, 4 quotient bits per cycle
  localparam int DivW     = 40;
  localparam int DivDenW  = 10;
  localparam int DivStep  = 4;
  localparam int DivIters = DivW / DivStep;
  localparam int DivCntW  = 4;

  // item kind carried on tuser
  typedef enum logic {
    OP_SENSOR = 1'b0,
    OP_RADIO  = 1'b1
  } op_t;

  // register index, byte address / 4
  typedef enum logic [2:0] {
    REG_P_GAIN    = 3'd0,
    REG_I_GAIN    = 3'd1,
    REG_D_GAIN    = 3'd2,
    REG_ILIMIT    = 3'd3,
    REG_SLIMIT    = 3'd4,
    REG_MIN_DUTY  = 3'd5,
    REG_MAX_DUTY  = 3'd6,
    REG_THR_GATE  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [GainW-1:0] p_gain;
    logic [GainW-1:0] i_gain;
    logic [GainW-1:0] d_gain;
    logic [IlimW-1:0] integral_limit;
    logic [SlimW-1:0] sum_limit;
    logic [DutyW-1:0] min_duty;
    logic [DutyW-1:0] max_duty;
    logic [DutyW-1:0] throttle_gate;
  } cfg_t;

  // register reset values
  localparam logic [GainW-1:0] RstPGain = 16'd24576;
  localparam logic [GainW-1:0] RstIGain = 16'd410;
  localparam logic [GainW-1:0] RstDGain = 16'd287;
  localparam logic [IlimW-1:0] RstIlim  = 23'd2560000;
  localparam logic [SlimW-1:0] RstSlim  = 11'd600;
  localparam logic [DutyW-1:0] RstMinDuty = 10'd10;
  localparam logic [DutyW-1:0] RstMaxDuty = 10'd900;
  localparam logic [DutyW-1:0] RstThrGate = 10'd10;

  // radio mapping constants
  localparam logic [MulBW-1:0]  SpMul    = 17'd2304;
  localparam logic signed [24:0] SpOff   = 25'sd5760050;
  localparam logic [MulBW-1:0]  ThrMul   = 17'd89;
  localparam logic signed [20:0] ThrOff  = 21'sd268000;
  localparam logic signed [20:0] ThrLo   = 21'sd1000;
  localparam logic signed [20:0] ThrHi   = 21'sd90000;
  localparam logic [DutyW-1:0]  ThrLoVal = 10'd10;
  localparam logic [DutyW-1:0]  ThrHiVal = 10'd900;

  // divisors
  localparam logic [DivDenW-1:0] DivIDen  = 10'd1000;
  localparam logic [DivDenW-1:0] DivSpDen = 10'd100;

endpackage

// ===== design/ppqm_mul.sv =====
// ----------------------------------------------------------------------------
// ppqm_mul
// Shared signed multiplier, 25 x 17 bits, product registered.
// ----------------------------------------------------------------------------
module ppqm_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ppqm_pkg::MulAW-1:0]   a,
  input  logic signed [ppqm_pkg::MulBW-1:0]   b,
  output logic signed [ppqm_pkg::ProdW-1:0]   product
);
  import ppqm_pkg::*;

  logic signed [ProdW-1:0] product_r;

  // product holds until the next issue
  always_ff @(posedge clk) begin
    if (en) begin
      product_r <= a * b;
    end
  end

  assign product = product_r;

endmodule

// ===== design/ppqm_div.sv =====
// ----------------------------------------------------------------------------
// ppqm_div
// Iterative restoring divider of an unsigned magnitude by a small constant,
// four quotient bits per cycle.
// ----------------------------------------------------------------------------
module ppqm_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ppqm_pkg::DivW-1:0]         dividend,
  input  logic [ppqm_pkg::DivDenW-1:0]      divisor,
  output logic                              busy,
  output logic [ppqm_pkg::DivW-1:0]         quotient,
  output logic                              rem_nz
);
  import ppqm_pkg::*;

  logic               busy_r;
  logic [DivCntW-1:0] cnt_r;
  logic [DivW-1:0]    num_r, num_nxt;
  logic [DivDenW-1:0] rem_r, rem_nxt;
  logic [DivDenW-1:0] den_r;

  // four restoring steps on the narrow remainder
  always_comb begin
    logic [DivDenW:0]   trial;
    logic [DivDenW-1:0] rem_v;
    logic [DivW-1:0]    num_v;
    rem_v = rem_r;
    num_v = num_r;
    for (int k = 0; k < DivStep; k++) begin
      trial = {rem_v, num_v[DivW-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_v = DivDenW'(trial - {1'b0, den_r});
        num_v = {num_v[DivW-2:0], 1'b1};
      end else begin
        rem_v = trial[DivDenW-1:0];
        num_v = {num_v[DivW-2:0], 1'b0};
      end
    end
    num_nxt = num_v;
    rem_nxt = rem_v;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DivCntW'(DivIters - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = num_r;
  assign rem_nz   = |rem_r;

endmodule

// ===== design/ppqm_cfg.sv =====
// ----------------------------------------------------------------------------
// ppqm_cfg
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module ppqm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppqm_pkg::AddrW-1:0]      paddr,
  input  logic [ppqm_pkg::CfgDataW-1:0]   pwdata,
  output logic [ppqm_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready,
  output ppqm_pkg::cfg_t                  cfg
);
  import ppqm_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx = reg_idx_t'(paddr[AddrW-1:2]);

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain         <= RstPGain;
      cfg_r.i_gain         <= RstIGain;
      cfg_r.d_gain         <= RstDGain;
      cfg_r.integral_limit <= RstIlim;
      cfg_r.sum_limit      <= RstSlim;
      cfg_r.min_duty       <= RstMinDuty;
      cfg_r.max_duty       <= RstMaxDuty;
      cfg_r.throttle_gate  <= RstThrGate;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_P_GAIN:   cfg_r.p_gain         <= pwdata[GainW-1:0];
        REG_I_GAIN:   cfg_r.i_gain         <= pwdata[GainW-1:0];
        REG_D_GAIN:   cfg_r.d_gain         <= pwdata[GainW-1:0];
        REG_ILIMIT:   cfg_r.integral_limit <= pwdata[IlimW-1:0];
        REG_SLIMIT:   cfg_r.sum_limit      <= pwdata[SlimW-1:0];
        REG_MIN_DUTY: cfg_r.min_duty       <= pwdata[DutyW-1:0];
        REG_MAX_DUTY: cfg_r.max_duty       <= pwdata[DutyW-1:0];
        REG_THR_GATE: cfg_r.throttle_gate  <= pwdata[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_P_GAIN:   prdata = CfgDataW'(cfg_r.p_gain);
      REG_I_GAIN:   prdata = CfgDataW'(cfg_r.i_gain);
      REG_D_GAIN:   prdata = CfgDataW'(cfg_r.d_gain);
      REG_ILIMIT:   prdata = CfgDataW'(cfg_r.integral_limit);
      REG_SLIMIT:   prdata = CfgDataW'(cfg_r.sum_limit);
      REG_MIN_DUTY: prdata = CfgDataW'(cfg_r.min_duty);
      REG_MAX_DUTY: prdata = CfgDataW'(cfg_r.max_duty);
      REG_THR_GATE: prdata = CfgDataW'(cfg_r.throttle_gate);
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

// ===== design/pitch_pid_quad_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// pitch_pid_quad_motor_mixer
// Pitch PID step and four-motor mixer, sequenced over a shared multiplier
// and a shared constant divider.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one word per item; in_tuser is the kind (sensor or radio).
//           A radio word sets the pitch setpoint and throttle and gives no
//           result. A sensor word runs one PID step and gives one result.
//   out_* : one word per sensor item: four motor duties and the pid sum.
//   cfg_* : APB-style register port, pready always high, writes while idle.
// Sequence
//   A sensor word runs its products, the divide, truncation, sum limit and
//   mix, the result registered in the mix step; a radio word runs two
//   products and two divisions. The pace is set by the single multiplier,
//   used once per product, and the divider, four quotient bits a cycle.
//   One item is worked on at a time; in_tready is low meanwhile.
// Reset
//   Registers take their defaults; integral, setpoint and throttle clear.
// Stall
//   A finished result waits in the output register; a new item can be
//   accepted meanwhile, but the next result waits until out_tready.
// ----------------------------------------------------------------------------
module pitch_pid_quad_motor_mixer (
  input  logic                            clk,
  input  logic                            rst_n,
  // op
  input  logic [0:0]                      in_tuser,
  // pitch_angle, pitch_rate, elapsed_ms, pitch_channel, throttle_channel
  input  logic [ppqm_pkg::InDataW-1:0]    in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // duty_front, duty_second, duty_third, duty_fourth, pid_sum
  output logic [ppqm_pkg::OutDataW-1:0]   out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ppqm_pkg::AddrW-1:0]      cfg_paddr,
  input  logic [ppqm_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [ppqm_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                            cfg_pready
);
  import ppqm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EDT, S_INT, S_P, S_I, S_D, S_DIV, S_TRUNC, S_LIM, S_MIX,
    S_RPCH, S_RTCH, S_RSDIV, S_RTDIV
  } state_t;

  cfg_t cfg;

  state_t                    state_r;
  logic                      out_tvalid_r;
  logic [OutDataW-1:0]       out_tdata_r;
  logic signed [AngleW-1:0]  integ_r;
  logic signed [AngleW-1:0]  setpoint_r;
  logic [DutyW-1:0]          throttle_r;
  logic signed [MulAW-1:0]   err_r;
  logic signed [AngleW-1:0]  rate_r;
  logic [DtW-1:0]            dt_r;
  logic [ChW-1:0]            pch_r;
  logic [ChW-1:0]            tch_r;
  logic signed [AccW-1:0]    acc_r;
  logic                      div_neg_r;
  logic signed [TruncW-1:0]  trunc_r;
  logic signed [SumW-1:0]    sum_r;

  logic                      mul_en;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [ProdW-1:0]   prod;
  logic                      div_start;
  logic [DivW-1:0]           div_dividend;
  logic [DivDenW-1:0]        div_divisor;
  logic                      div_busy;
  logic [DivW-1:0]           quo;
  logic                      rem_nz;

  logic signed [AngleW-1:0]  in_angle;
  logic signed [AngleW-1:0]  in_rate;
  logic [DtW-1:0]            in_dt;
  logic [ProdW-1:0]          prod_abs;
  logic signed [ProdW:0]     integ_sum, lim_pos, lim_neg;
  logic signed [AngleW-1:0]  integ_new;
  logic signed [24:0]        sp_n;
  logic [24:0]               sp_abs;
  logic signed [20:0]        thr_t;
  logic signed [AccW-1:0]    i_term;
  logic signed [AngleW-1:0]  sp_new;
  logic [DutyW-1:0]          thr_new;
  logic signed [AccW-1:0]    acc_bias;
  logic signed [TruncW-1:0]  slim_pos, slim_neg, sum_lim;
  logic signed [12:0]        minus_side, plus_side;
  logic [DutyW-1:0]          d_minus, d_plus;

  // clamp to the duty limits, low limit tested first
  function automatic logic [DutyW-1:0] duty_clamp(input logic signed [12:0] x,
                                                  input logic [DutyW-1:0] lo,
                                                  input logic [DutyW-1:0] hi);
    logic [DutyW-1:0] r;
    if (x < $signed({3'b0, lo})) r = lo;
    else if (x > $signed({3'b0, hi})) r = hi;
    else r = x[DutyW-1:0];
    return r;
  endfunction

  ppqm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ppqm_mul u_mul (
    .clk     (clk),
    .en      (mul_en),
    .a       (mul_a),
    .b       (mul_b),
    .product (prod)
  );

  ppqm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quo),
    .rem_nz   (rem_nz)
  );

  // input word fields
  assign in_angle = $signed(in_tdata[AngleLsb +: AngleW]);
  assign in_rate  = $signed(in_tdata[RateLsb +: AngleW]);
  assign in_dt    = in_tdata[DtLsb +: DtW];

  // arithmetic around the shared units
  always_comb begin
    prod_abs  = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
    // integral update and clamp
    integ_sum = $signed({{(ProdW + 1 - AngleW){integ_r[AngleW-1]}}, integ_r})
              + $signed({prod[ProdW-1], prod});
    lim_pos   = $signed({{(ProdW + 1 - IlimW){1'b0}}, cfg.integral_limit});
    lim_neg   = -lim_pos;
    if (integ_sum < lim_neg) integ_new = lim_neg[AngleW-1:0];
    else if (integ_sum > lim_pos) integ_new = lim_pos[AngleW-1:0];
    else integ_new = integ_sum[AngleW-1:0];
    // radio mapping
    sp_n   = SpOff - $signed(prod[24:0]);
    sp_abs = sp_n[24] ? 25'(-sp_n) : 25'(sp_n);
    thr_t  = ThrOff - $signed(prod[20:0]);
    // signed quotients from the magnitude divider
    i_term = div_neg_r ? -$signed({{(AccW - DivW){1'b0}}, quo})
                       : $signed({{(AccW - DivW){1'b0}}, quo});
    sp_new = div_neg_r ? AngleW'(-$signed(quo[AngleW-1:0]) - AngleW'(rem_nz))
                       : $signed(quo[AngleW-1:0]);
    if (thr_t < ThrLo) thr_new = ThrLoVal;
    else if (thr_t > ThrHi) thr_new = ThrHiVal;
    else thr_new = quo[DutyW-1:0];
    // sum to whole units, truncated toward zero
    acc_bias = acc_r + (acc_r[AccW-1] ? AccW'((1 << 20) - 1) : AccW'(0));
    slim_pos = $signed({{(TruncW - SlimW){1'b0}}, cfg.sum_limit});
    slim_neg = -slim_pos;
    if (trunc_r < slim_neg) sum_lim = slim_neg;
    else if (trunc_r > slim_pos) sum_lim = slim_pos;
    else sum_lim = trunc_r;
    // motor mix
    if (throttle_r > cfg.throttle_gate) begin
      minus_side = $signed({3'b0, throttle_r}) - $signed({sum_r[SumW-1], sum_r});
      plus_side  = $signed({3'b0, throttle_r}) + $signed({sum_r[SumW-1], sum_r});
    end else begin
      minus_side = $signed({3'b0, cfg.min_duty});
      plus_side  = $signed({3'b0, cfg.min_duty});
    end
    d_minus = duty_clamp(minus_side, cfg.min_duty, cfg.max_duty);
    d_plus  = duty_clamp(plus_side, cfg.min_duty, cfg.max_duty);
  end

  // shared unit operand selection
  always_comb begin
    mul_en       = 1'b0;
    mul_a        = err_r;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = prod_abs[DivW-1:0];
    div_divisor  = DivIDen;
    case (state_r)
      S_EDT: begin
        mul_en = 1'b1;
        mul_b  = $signed({{(MulBW - DtW){1'b0}}, dt_r});
      end
      S_INT: begin
        mul_en = 1'b1;
        mul_b  = $signed({1'b0, cfg.p_gain});
      end
      S_P: begin
        mul_en = 1'b1;
        mul_a  = $signed({integ_r[AngleW-1], integ_r});
        mul_b  = $signed({1'b0, cfg.i_gain});
      end
      S_I: begin
        mul_en    = 1'b1;
        mul_a     = $signed({rate_r[AngleW-1], rate_r});
        mul_b     = $signed({1'b0, cfg.d_gain});
        div_start = 1'b1;
      end
      S_RPCH: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MulAW - ChW){1'b0}}, pch_r});
        mul_b  = $signed(SpMul);
      end
      S_RTCH: begin
        mul_en       = 1'b1;
        mul_a        = $signed({{(MulAW - ChW){1'b0}}, tch_r});
        mul_b        = $signed(ThrMul);
        div_start    = 1'b1;
        div_dividend = {{(DivW - 25){1'b0}}, sp_abs};
        div_divisor  = DivSpDen;
      end
      S_RSDIV: begin
        div_start    = !div_busy;
        div_dividend = {{(DivW - 21){1'b0}}, thr_t};
        div_divisor  = DivSpDen;
      end
      default: ;
    endcase
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      integ_r      <= '0;
      setpoint_r   <= '0;
      throttle_r   <= '0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            pch_r  <= in_tdata[PchLsb +: ChW];
            tch_r  <= in_tdata[TchLsb +: ChW];
            err_r  <= $signed({setpoint_r[AngleW-1], setpoint_r})
                    - $signed({in_angle[AngleW-1], in_angle});
            rate_r <= in_rate;
            dt_r   <= (in_dt == '0) ? DtW'(1) : in_dt;
            if (op_t'(in_tuser[0]) == OP_RADIO) state_r <= S_RPCH;
            else state_r <= S_EDT;
          end
        end
        S_EDT: state_r <= S_INT;
        S_INT: begin
          integ_r <= integ_new;
          state_r <= S_P;
        end
        S_P: begin
          acc_r   <= AccW'(prod);
          state_r <= S_I;
        end
        S_I: begin
          div_neg_r <= prod[ProdW-1];
          state_r   <= S_D;
        end
        S_D: begin
          acc_r   <= acc_r - AccW'(prod);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            acc_r   <= acc_r + i_term;
            state_r <= S_TRUNC;
          end
        end
        S_TRUNC: begin
          trunc_r <= acc_bias[AccW-1:20];
          state_r <= S_LIM;
        end
        S_LIM: begin
          sum_r   <= sum_lim[SumW-1:0];
          state_r <= S_MIX;
        end
        S_MIX: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {{(OutDataW - SumW - 4 * DutyW){1'b0}}, sum_r,
                             d_plus, d_minus, d_plus, d_minus};
            state_r      <= S_IDLE;
          end
        end
        S_RPCH: state_r <= S_RTCH;
        S_RTCH: begin
          div_neg_r <= sp_n[24];
          state_r   <= S_RSDIV;
        end
        S_RSDIV: begin
          if (!div_busy) begin
            setpoint_r <= sp_new;
            div_neg_r  <= 1'b0;
            state_r    <= S_RTDIV;
          end
        end
        S_RTDIV: begin
          if (!div_busy) begin
            throttle_r <= thr_new;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== design/ppqm_checker.sv =====
// ----------------------------------------------------------------------------
// ppqm_checker
// Port-level checks on the pitch PID quad motor mixer, bound to the top.
// ----------------------------------------------------------------------------
module ppqm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ppqm_pkg::OutDataW-1:0]  out_tdata
);
  import ppqm_pkg::*;

  // one item at a time: an accepted word drops ready
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in work");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed");

  // front and third motors match, second and fourth match
  a_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[9:0] == out_tdata[29:20]) &&
                    (out_tdata[19:10] == out_tdata[39:30])))
    else $error("motor pairs disagree");

  // a new result only comes out of a busy sequencer
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared from an idle block");

endmodule

bind pitch_pid_quad_motor_mixer ppqm_checker u_ppqm_checker (.*);
